// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file dlr_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define DLR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define DLR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/dlr_pkg.sv =====
// ----------------------------------------------------------------------------
// dlr_pkg
// Shared constants and controller/datapath interface types of the DDA line
// rasterizer.
// ----------------------------------------------------------------------------
package dlr_pkg;

	// coordinate width, fixed by the port fields
	localparam int COORD_BITS = 12;
	// default number of slope fraction bits
	localparam int FRAC_BITS_DEF = 16;
	// reset value of the largest screen row
	localparam logic [COORD_BITS-1:0] SCREEN_MAX_Y_RST = COORD_BITS'(479);

	// command codes
	localparam logic CMD_START   = 1'b0;
	localparam logic CMD_ADVANCE = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic load_line;   // latch endpoints, start slope divide
		logic slope_load;  // store finished quotient as slope
		logic advance;     // emit one pixel if a line is active
	} dlr_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;    // output register can take a word this cycle
		logic div_done;    // divider quotient is final
	} dlr_status_t;

endpackage

// ===== rtl/dlr_ctrl.sv =====
// ----------------------------------------------------------------------------
// dlr_ctrl
// Controller: gates the input channel and sequences line setup around the
// slope divider.
// ----------------------------------------------------------------------------
module dlr_ctrl
	import dlr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        command,
	input  dlr_status_t status,
	output logic        in_ready,
	output dlr_cmd_t    cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DIV  = 1'b1;

	logic state_q;
	logic fire;

	// take a word only when idle and the output register has room
	assign in_ready = (state_q == ST_IDLE) && status.out_free;
	assign fire     = in_valid && in_ready;

	// command decode
	always_comb begin
		cmd.load_line  = fire && (command == CMD_START);
		cmd.advance    = fire && (command == CMD_ADVANCE);
		cmd.slope_load = (state_q == ST_DIV) && status.div_done;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.load_line)
						state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (status.div_done)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/dlr_div.sv =====
// ----------------------------------------------------------------------------
// dlr_div
// Restoring divider, one quotient bit per cycle. Unsigned numerator of
// QW bits over a COORD_BITS divisor; done pulses when the quotient is final.
// ----------------------------------------------------------------------------
module dlr_div
	import dlr_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [COORD_BITS+FRAC_BITS-1:0] num,
	input  logic [COORD_BITS-1:0]           den,
	output logic                            done,
	output logic [COORD_BITS+FRAC_BITS-1:0] quo
);

	localparam int QW    = COORD_BITS + FRAC_BITS;
	localparam int CNT_W = $clog2(QW);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QW - 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [COORD_BITS-1:0] rem_q;
	logic [COORD_BITS-1:0] den_q;
	logic [QW-1:0]         quo_q;

	logic [COORD_BITS:0]   rem_sh;
	logic [COORD_BITS+1:0] trial;
	logic                  ge;

	// one restoring step
	always_comb begin
		rem_sh = {rem_q, quo_q[QW-1]};
		trial  = {1'b0, rem_sh} - {2'b00, den_q};
		ge     = !trial[COORD_BITS+1];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_LAST);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_LAST)
					busy_q <= 1'b0;
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= ge ? trial[COORD_BITS-1:0] : rem_sh[COORD_BITS-1:0];
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ===== rtl/dlr_datapath.sv =====
// ----------------------------------------------------------------------------
// dlr_datapath
// Endpoint ordering, slope divider, DDA stepping registers, the row-flip
// register and the output word register.
// ----------------------------------------------------------------------------
module dlr_datapath
	import dlr_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dlr_cmd_t              cmd,
	output dlr_status_t           status,
	input  logic [COORD_BITS-1:0] x_start,
	input  logic [COORD_BITS-1:0] y_start,
	input  logic [COORD_BITS-1:0] x_end,
	input  logic [COORD_BITS-1:0] y_end,
	input  logic                  cfg_we,
	input  logic [COORD_BITS-1:0] cfg_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COORD_BITS-1:0] pixel_x,
	output logic [COORD_BITS-1:0] pixel_y,
	output logic                  last
);

	localparam int CW    = COORD_BITS;
	localparam int QW    = COORD_BITS + FRAC_BITS;
	localparam int ACC_W = COORD_BITS + FRAC_BITS + 2;

	// line state
	logic              active_q;
	logic              x_major_q;
	logic [CW-1:0]     major_pos_q;
	logic [CW-1:0]     major_stop_q;
	logic [ACC_W-1:0]  minor_acc_q;
	logic [ACC_W-1:0]  slope_q;
	logic              neg_q;
	logic              flat_q;
	logic [CW-1:0]     smy_q;

	// output word
	logic              out_valid_q;
	logic [CW-1:0]     pixel_x_q;
	logic [CW-1:0]     pixel_y_q;
	logic              last_q;

	// setup logic
	logic [CW:0]       dx, dy, dmin_u;
	logic [CW-1:0]     adx, ady;
	logic              x_maj;
	logic [CW-1:0]     ma, mb, na, nb;
	logic              swap;
	logic [CW-1:0]     lo_maj, hi_maj, lo_min, hi_min;
	logic [CW-1:0]     dmaj, dmin_mag;
	logic              dmin_neg;
	logic [QW-1:0]     num;

	// divider
	logic              div_done;
	logic [QW-1:0]     quo;
	logic [ACC_W-1:0]  quo_ext;

	// stepping
	logic [CW-1:0]     minor;
	logic [CW-1:0]     px, py;
	logic              is_last;
	logic              step;

	// major axis choice and endpoint ordering
	always_comb begin
		dx       = {1'b0, x_end} - {1'b0, x_start};
		dy       = {1'b0, y_end} - {1'b0, y_start};
		adx      = dx[CW] ? (~dx[CW-1:0] + 1'b1) : dx[CW-1:0];
		ady      = dy[CW] ? (~dy[CW-1:0] + 1'b1) : dy[CW-1:0];
		x_maj    = (adx >= ady);
		ma       = x_maj ? x_start : y_start;
		mb       = x_maj ? x_end   : y_end;
		na       = x_maj ? y_start : x_start;
		nb       = x_maj ? y_end   : x_end;
		swap     = (ma > mb);
		lo_maj   = swap ? mb : ma;
		hi_maj   = swap ? ma : mb;
		lo_min   = swap ? nb : na;
		hi_min   = swap ? na : nb;
		dmaj     = hi_maj - lo_maj;
		dmin_u   = {1'b0, hi_min} - {1'b0, lo_min};
		dmin_neg = dmin_u[CW];
		dmin_mag = dmin_neg ? (~dmin_u[CW-1:0] + 1'b1) : dmin_u[CW-1:0];
		num      = {dmin_mag, {FRAC_BITS{1'b0}}};
	end

	dlr_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.load_line),
		.num    (num),
		.den    (dmaj),
		.done   (div_done),
		.quo    (quo)
	);

	assign quo_ext = {2'b00, quo};

	// pixel of the current step; a negative accumulator reads as minor coordinate zero
	always_comb begin
		minor   = minor_acc_q[ACC_W-1] ? '0 : minor_acc_q[FRAC_BITS +: CW];
		px      = x_major_q ? major_pos_q : minor;
		py      = x_major_q ? minor : major_pos_q;
		is_last = (major_pos_q == major_stop_q);
		step    = cmd.advance && active_q;
	end

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			smy_q <= SCREEN_MAX_Y_RST;
		else if (cfg_we)
			smy_q <= cfg_data;
	end

	// line state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			x_major_q    <= 1'b0;
			major_pos_q  <= '0;
			major_stop_q <= '0;
			minor_acc_q  <= '0;
			slope_q      <= '0;
			neg_q        <= 1'b0;
			flat_q       <= 1'b0;
		end else begin
			priority if (cmd.load_line) begin
				active_q     <= 1'b1;
				x_major_q    <= x_maj;
				major_pos_q  <= lo_maj;
				major_stop_q <= hi_maj;
				minor_acc_q  <= {2'b00, lo_min, {FRAC_BITS{1'b0}}};
				slope_q      <= '0;
				neg_q        <= dmin_neg;
				flat_q       <= (dmaj == '0);
			end else if (cmd.slope_load) begin
				// zero-length major axis leaves the slope at zero
				if (!flat_q)
					slope_q <= neg_q ? (~quo_ext + 1'b1) : quo_ext;
			end else if (step) begin
				if (is_last) begin
					active_q <= 1'b0;
				end else begin
					major_pos_q <= major_pos_q + 1'b1;
					minor_acc_q <= minor_acc_q + slope_q;
				end
			end
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (step)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (step) begin
			pixel_x_q <= px;
			pixel_y_q <= smy_q - py;
			last_q    <= is_last;
		end
	end

	always_comb begin
		status.out_free = !out_valid_q || out_ready;
		status.div_done = div_done;
	end

	assign out_valid = out_valid_q;
	assign pixel_x   = pixel_x_q;
	assign pixel_y   = pixel_y_q;
	assign last      = last_q;

endmodule

// ===== rtl/dda_line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// dda_line_rasterizer
// DDA line rasterizer: one pixel word per advance command while a line is active.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries a command word. A start word
//   loads x_start/y_start/x_end/y_end and yields no output; an advance word
//   yields one pixel word (pixel_x, pixel_y, last) while a line is active,
//   and nothing otherwise.
//   A start word occupies the block until the slope divider is done; the
//   divider retires one quotient bit per cycle.
//   Advance words are taken one per cycle while out_ready is high; the pixel
//   word is valid on the output channel in the cycle after acceptance.
//   Output words sit in a single output register; while it is full and
//   out_ready is low, in_ready is low. It can drain and refill in the same cycle.
//   Config channel (cfg_valid/cfg_ready, always ready) writes screen_max_y;
//   rows are flipped as screen_max_y - y, modulo 2^12.
//   Reset (arst_n low) drops any active line, empties the output register
//   and sets screen_max_y to 479.
// ----------------------------------------------------------------------------
module dda_line_rasterizer
	import dlr_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  command,
	input  logic [COORD_BITS-1:0] x_start,
	input  logic [COORD_BITS-1:0] y_start,
	input  logic [COORD_BITS-1:0] x_end,
	input  logic [COORD_BITS-1:0] y_end,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COORD_BITS-1:0] pixel_x,
	output logic [COORD_BITS-1:0] pixel_y,
	output logic                  last,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [COORD_BITS-1:0] screen_max_y
);

	dlr_cmd_t    cmd;
	dlr_status_t status;

	// config register takes a word every cycle
	assign cfg_ready = 1'b1;

	dlr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.command  (command),
		.status   (status),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	dlr_datapath #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.x_start   (x_start),
		.y_start   (y_start),
		.x_end     (x_end),
		.y_end     (y_end),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_data  (screen_max_y),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.last      (last)
	);

endmodule

// ===== rtl/dlr_checker.sv =====
// ----------------------------------------------------------------------------
// dlr_checker
// Port-level checks of the rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dlr_checker
	import dlr_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  command,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [COORD_BITS-1:0] pixel_x,
	input logic [COORD_BITS-1:0] pixel_y,
	input logic                  last
);

	logic stalled;
	logic start_fire;
	logic adv_fire;

	assign stalled    = out_valid && !out_ready;
	assign start_fire = in_valid && in_ready && (command == CMD_START);
	assign adv_fire   = in_valid && in_ready && (command == CMD_ADVANCE);

	// a stalled output word holds
	`DLR_ASSERT_NEXT(a_out_hold, clk, arst_n, stalled, out_valid && $stable(pixel_x) && $stable(pixel_y) && $stable(last))

	// no word taken while the output register is full and stalled
	`DLR_ASSERT_IMP(a_no_take_stalled, clk, arst_n, stalled, !in_ready)

	// a start word keeps the block busy on the next cycle (slope divide)
	`DLR_ASSERT_NEXT(a_start_busy, clk, arst_n, start_fire, !in_ready)

	// an output word only appears after an accepted advance
	`DLR_ASSERT_IMP(a_out_from_adv, clk, arst_n, $rose(out_valid), $past(adv_fire))

endmodule

bind dda_line_rasterizer dlr_checker u_dlr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.command   (command),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.pixel_x   (pixel_x),
	.pixel_y   (pixel_y),
	.last      (last)
);
